>>> hdl/sacmc_pkg.sv
// Package for the set-associative cache miss classifier.
// Types, constants and request/result structs; no dependencies.
package sacmc_pkg;

  localparam int unsigned MaxWays  = 8;
  localparam int unsigned MaxSets  = 1024;
  localparam int unsigned AgeWidth = 32;
  localparam int unsigned WayW     = $clog2(MaxWays);
  localparam int unsigned SetW     = $clog2(MaxSets);
  localparam int unsigned WayCntW  = $clog2(MaxWays + 1);

  typedef enum logic [2:0] {
    OUT_HIT        = 3'd0,
    OUT_COMPULSORY = 3'd1,
    OUT_CAPACITY   = 3'd2,
    OUT_CONFLICT   = 3'd3,
    OUT_EMPTY_ERR  = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_WAYS   = 2'd1,
    REG_INDEX  = 2'd2,
    REG_OFFSET = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] address;
    logic        is_store;
    logic        seen_before;
    logic        shadow_capacity_miss;
  } req_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic       refill_read;
    logic       write_back;
    logic [2:0] way_used;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } cmd_t;

  typedef logic [AgeWidth-1:0] age_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] line;
    logic        dirty;
    age_t        age;
  } entry_t;

endpackage

>>> hdl/set_assoc_cache_miss_classifier.sv
// Set-associative cache tag store with miss classification, top level.
// After reset a clearing pass invalidates every set; input and configuration
// stall until it ends. Each request then passes through accept, set row read,
// update and row write, and result; the result is offered from the result state
// after the set memory row read-modify-write. Results are held until taken;
// configuration is taken only while no request is offered or in flight.
// Depends on sacmc_pkg, sacmc_ctrl, sacmc_dp.
module set_assoc_cache_miss_classifier import sacmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  cmd_t cmd;
  logic clr_done;

  sacmc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cfg_ready_o, .clr_done_i(clr_done), .cmd_o(cmd)
  );

  sacmc_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_idx_i(cfg_index_i),
    .cfg_data_i, .clr_done_o(clr_done), .rsp_o(out_data_o)
  );

endmodule

>>> hdl/sacmc_ctrl.sv
// Controller state machine of the cache miss classifier.
// Depends on sacmc_pkg.
module sacmc_ctrl import sacmc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic cfg_ready_o,
  input  logic clr_done_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (clr_done_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = !in_valid_i;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: state_d = ST_UPDATE;
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !out_valid_o)
    else $error("result shown right after capture");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_o)
    else $error("no result after update");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.update))
    else $error("capture and update together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> (in_stall_o && !cfg_ready_o))
    else $error("input open during clear");

endmodule

>>> hdl/sacmc_dp.sv
// Datapath: config registers, set memory, hit/victim logic, result register.
// Depends on sacmc_pkg.
module sacmc_dp import sacmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  output logic        clr_done_o,
  output rsp_t        rsp_o
);

  logic       policy_q;
  logic [3:0] ways_q, index_q, offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      ways_q   <= 4'd1;
      index_q  <= 4'd10;
      offset_q <= 4'd5;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_POLICY: policy_q <= cfg_data_i[0];
        REG_WAYS:   ways_q   <= cfg_data_i;
        REG_INDEX:  index_q  <= cfg_data_i;
        REG_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  req_t            req_q;
  logic [31:0]     line_q;
  logic [SetW-1:0] set_q;
  logic [31:0]     line_d;
  logic [31:0]     imask;

  assign line_d = req_i.address >> offset_q;
  assign imask  = (32'd1 << index_q) - 32'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_i;
      line_q <= line_d;
      set_q  <= SetW'(line_d & imask);
    end
  end

  // clearing pass after reset, one set per cycle
  logic [SetW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + SetW'(1);
    end
  end

  assign clr_done_o = (clr_idx_q == SetW'(MaxSets - 1));

  // set memory, one row per set
  entry_t mem_q [MaxSets][MaxWays];
  entry_t row_q [MaxWays];

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < MaxWays; w++) begin
      row_q[w] <= mem_q[set_q][w];
    end
  end

  logic [WayCntW-1:0] nways;
  logic [MaxWays-1:0] vrow, inuse, hitv, emptyv;
  age_t               aged [MaxWays];
  logic               hit, empty;
  logic [WayW-1:0]    hitw, emptyw, oldw, victim;
  age_t               best;
  entry_t             wrow [MaxWays];
  rsp_t               rsp_d;

  always_comb begin
    if (ways_q == 4'd0) begin
      nways = WayCntW'(1);
    end else if (ways_q > 4'(MaxWays)) begin
      nways = WayCntW'(MaxWays);
    end else begin
      nways = WayCntW'(ways_q);
    end
    for (int w = 0; w < MaxWays; w++) begin
      vrow[w]   = row_q[w].valid;
      inuse[w]  = (WayCntW'(w) < nways);
      aged[w]   = row_q[w].age;
      if (inuse[w] && vrow[w] && row_q[w].age != '1) begin
        aged[w] = row_q[w].age + age_t'(1);
      end
      hitv[w]   = inuse[w] && vrow[w] && (row_q[w].line == line_q);
      emptyv[w] = inuse[w] && !vrow[w];
    end
    hit = 1'b0; hitw = '0; empty = 1'b0; emptyw = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit = 1'b1; hitw = WayW'(w);
      end
      if (emptyv[w]) begin
        empty = 1'b1; emptyw = WayW'(w);
      end
    end
    best = '0; oldw = '0;
    for (int w = 0; w < MaxWays; w++) begin
      if (inuse[w] && vrow[w] && aged[w] > best) begin
        best = aged[w]; oldw = WayW'(w);
      end
    end
    victim = empty ? emptyw : oldw;
    for (int w = 0; w < MaxWays; w++) begin
      wrow[w]     = row_q[w];
      wrow[w].age = aged[w];
    end
    rsp_d = '0;
    if (hit) begin
      if (policy_q) begin
        wrow[hitw].age = '0;
      end
      if (req_q.is_store) begin
        wrow[hitw].dirty = 1'b1;
      end
      rsp_d.outcome  = OUT_HIT;
      rsp_d.way_used = 3'(hitw);
    end else begin
      wrow[victim].valid = 1'b1;
      wrow[victim].line  = line_q;
      wrow[victim].age   = '0;
      wrow[victim].dirty = req_q.is_store;
      rsp_d.refill_read  = 1'b1;
      rsp_d.way_used     = 3'(victim);
      if (empty) begin
        rsp_d.outcome = req_q.seen_before ? OUT_EMPTY_ERR : OUT_COMPULSORY;
      end else begin
        rsp_d.write_back = row_q[oldw].dirty;
        if (!req_q.seen_before) begin
          rsp_d.outcome = OUT_COMPULSORY;
        end else begin
          rsp_d.outcome = req_q.shadow_capacity_miss ? OUT_CAPACITY : OUT_CONFLICT;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      for (int w = 0; w < MaxWays; w++) begin
        mem_q[clr_idx_q][w] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int w = 0; w < MaxWays; w++) begin
        mem_q[set_q][w] <= wrow[w];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rsp_o <= rsp_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && hit |-> !rsp_d.refill_read)
    else $error("refill on hit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && empty |-> !rsp_d.write_back)
    else $error("write-back on empty fill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $onehot0(hitv))
    else $error("multiple hits in set");

endmodule

>>> test/tb.sv
// Testbench for set_assoc_cache_miss_classifier: directed and random requests
// checked against an in-bench tag/age model of the cache set store.
// Depends on sacmc_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
  import sacmc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  set_assoc_cache_miss_classifier DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cache model state
  logic [31:0] line_tag [MaxSets][MaxWays];
  logic        line_valid [MaxSets][MaxWays];
  logic        line_dirty [MaxSets][MaxWays];
  logic [31:0] line_age [MaxSets][MaxWays];
  logic        lru_mode;
  logic [3:0]  ways_cfg, index_cfg, offset_cfg;

  rsp_t expected_rsp [$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned hold_left = 0;
  bit hold_go = 0;
  int unsigned cycles = 0;
  logic [31:0] addr_pool [32];

  function automatic rsp_t classify_access(req_t r);
    int unsigned nw, ln, st, w, victim;
    logic [31:0] best;
    rsp_t p;
    nw = (ways_cfg == 0) ? 1 : ((ways_cfg > MaxWays) ? MaxWays : ways_cfg);
    ln = r.address >> offset_cfg;
    st = (ln & ((32'd1 << index_cfg) - 1)) % MaxSets;
    for (w = 0; w < nw; w++)
      if (line_valid[st][w] && line_age[st][w] != 32'hffff_ffff)
        line_age[st][w]++;
    for (w = 0; w < nw; w++) begin
      if (line_valid[st][w] && line_tag[st][w] == ln) begin
        if (lru_mode) line_age[st][w] = 0;
        if (r.is_store) line_dirty[st][w] = 1'b1;
        p.outcome = OUT_HIT;
        p.refill_read = 1'b0;
        p.write_back = 1'b0;
        p.way_used = w[2:0];
        return p;
      end
    end
    for (w = 0; w < nw; w++)
      if (!line_valid[st][w]) break;
    p.write_back = 1'b0;
    if (w < nw) begin
      victim = w;
      p.outcome = r.seen_before ? OUT_EMPTY_ERR : OUT_COMPULSORY;
    end else begin
      victim = 0;
      best = 0;
      for (w = 0; w < nw; w++)
        if (line_age[st][w] > best) begin
          best = line_age[st][w];
          victim = w;
        end
      p.write_back = line_dirty[st][victim];
      if (!r.seen_before) p.outcome = OUT_COMPULSORY;
      else p.outcome = r.shadow_capacity_miss ? OUT_CAPACITY : OUT_CONFLICT;
    end
    line_valid[st][victim] = 1'b1;
    line_tag[st][victim] = ln;
    line_age[st][victim] = 0;
    line_dirty[st][victim] = r.is_store;
    p.refill_read = 1'b1;
    p.way_used = victim[2:0];
    return p;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected result", out_data, 0);
      end else begin
        rsp_t e;
        e = expected_rsp.pop_front();
        if (out_data.outcome !== e.outcome) report("outcome", out_data.outcome, e.outcome);
        if (out_data.refill_read !== e.refill_read)
          report("refill_read", out_data.refill_read, e.refill_read);
        if (out_data.write_back !== e.write_back)
          report("write_back", out_data.write_back, e.write_back);
        if (out_data.way_used !== e.way_used) report("way_used", out_data.way_used, e.way_used);
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 300;
      hold_go = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    expected_rsp.push_back(classify_access(r));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [3:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POLICY: lru_mode = val[0];
      REG_WAYS:   ways_cfg = val;
      REG_INDEX:  index_cfg = val;
      default:    offset_cfg = val;
    endcase
  endtask

  function automatic req_t rand_req();
    req_t r;
    r.address = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(31)] ^ $urandom_range(3)
                                          : $urandom;
    r.is_store = 1'($urandom_range(1));
    r.seen_before = 1'($urandom_range(1));
    r.shadow_capacity_miss = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic req_t mk(logic [31:0] a, bit s, bit sb, bit sc);
    req_t r;
    r.address = a;
    r.is_store = s;
    r.seen_before = sb;
    r.shadow_capacity_miss = sc;
    return r;
  endfunction

  task automatic test_directed();
    write_reg(REG_POLICY, 4'd1);
    write_reg(REG_WAYS, 4'd2);
    write_reg(REG_INDEX, 4'd1);
    write_reg(REG_OFFSET, 4'd2);
    send_request(mk(32'h0000_0000, 0, 0, 0)); // compulsory, way 0
    send_request(mk(32'h0000_0003, 1, 1, 0)); // hit, store dirties
    send_request(mk(32'hffff_fff8, 0, 1, 0)); // seen before, empty way
    send_request(mk(32'h0000_0010, 0, 1, 1)); // capacity, dirty victim
    send_request(mk(32'h0000_0020, 1, 1, 0)); // conflict
    send_request(mk(32'h0000_0020, 0, 1, 0));
    send_request(mk(32'h0000_0010, 1, 0, 1)); // hit on way 0, store dirties
    send_request(mk(32'hffff_ffff, 1, 1, 1)); // other set, empty
    send_request(mk(32'hffff_fffc, 0, 1, 1));
    send_request(mk(32'h7fff_fffc, 0, 1, 1));
    send_request(mk(32'h8000_0004, 1, 1, 0));
    write_reg(REG_POLICY, 4'd0);
    send_request(mk(32'h0000_0020, 0, 1, 0)); // FIFO hit keeps age
    send_request(mk(32'h0000_0040, 0, 1, 1));
    send_request(mk(32'h0000_0050, 0, 1, 0));
    send_request(mk(32'h0000_0040, 1, 1, 0));
    send_request(mk(32'h0000_0060, 0, 0, 0));
  endtask

  task automatic test_config_sweep();
    logic [3:0] ways [8] = '{0, 1, 15, 8, 3, 9, 2, 7};
    logic [3:0] idxs [8] = '{0, 15, 10, 2, 0, 1, 11, 4};
    logic [3:0] offs [8] = '{0, 15, 12, 5, 3, 0, 13, 1};
    for (int c = 0; c < 8; c++) begin
      write_reg(REG_POLICY, 4'(c[0]));
      write_reg(REG_WAYS, ways[c]);
      write_reg(REG_INDEX, idxs[c]);
      write_reg(REG_OFFSET, offs[c]);
      repeat (60) send_request(rand_req());
    end
  endtask

  task automatic test_idle_mix();
    int unsigned ip [4] = '{0, 79, 0, 21};
    int unsigned sp [4] = '{0, 0, 79, 21};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      idle_pct = ip[ph];
      stall_pct = sp[ph];
      write_reg(REG_POLICY, 4'($urandom_range(1)));
      write_reg(REG_WAYS, 4'($urandom_range(8, 1)));
      write_reg(REG_INDEX, 4'($urandom_range(3)));
      write_reg(REG_OFFSET, 4'($urandom_range(6)));
      repeat (250) send_request(rand_req());
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_go = 1;
    repeat (75) send_request(rand_req());
    drain();
    repeat (75) send_request(rand_req());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_POLICY;
    cfg_data = '0;
    lru_mode = 1'b0;
    ways_cfg = 4'd1;
    index_cfg = 4'd10;
    offset_cfg = 4'd5;
    for (int s = 0; s < MaxSets; s++)
      for (int w = 0; w < MaxWays; w++) begin
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
        line_age[s][w] = 0;
        line_tag[s][w] = 0;
      end
    foreach (addr_pool[i]) addr_pool[i] = $urandom & 32'h0000_3ffc;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_idle_mix();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
